>>> hdl/ltb_pkg.sv
// ---------------------------------------------------------------------------
// ltb_pkg
// shared types and constants of the ladder timer bank
// ---------------------------------------------------------------------------
package ltb_pkg;

   localparam int NUM_TIMERS = 4;
   localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam logic [1:0] OP_ON_DELAY  = 2'd0;
   localparam logic [1:0] OP_OFF_DELAY = 2'd1;
   localparam logic [1:0] OP_RESET     = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  timer_index;
      logic        rung;
      logic [31:0] preset_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        enabled;
      logic        timing;
      logic        done_res;
      logic [31:0] elapsed_ms;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic        timing;
      logic        done;
      logic [31:0] start;
      logic [31:0] elapsed;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
   } ram_wr_type;

endpackage

>>> hdl/ltb_state_ram.sv
// ---------------------------------------------------------------------------
// ltb_state_ram
// timer state memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module ltb_state_ram (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ltb_pkg::ADDR_W-1:0] rd_addr,
   output ltb_pkg::entry_type        rd_data,
   input  ltb_pkg::ram_wr_type       wr
);

   ltb_pkg::entry_type mem [ltb_pkg::NUM_TIMERS];
   ltb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ltb_step_unit.sv
// ---------------------------------------------------------------------------
// ltb_step_unit
// next timer state and result for one on-delay, off-delay or reset step
// ---------------------------------------------------------------------------
module ltb_step_unit (
   input  ltb_pkg::req_type   req,
   input  logic               in_range,
   input  ltb_pkg::entry_type cur,
   output ltb_pkg::entry_type nxt,
   output logic               wr_en,
   output ltb_pkg::rsp_type   rsp
);

   logic [31:0] start_sel;
   logic [31:0] diff;
   logic        reached;

   always_comb begin
      start_sel = cur.start;
      case (req.func)
         ltb_pkg::OP_ON_DELAY: begin
            if (req.rung && !cur.enabled) begin
               start_sel = req.now_ms;
            end
         end
         ltb_pkg::OP_OFF_DELAY: begin
            if (!req.rung && cur.enabled && !cur.timing) begin
               start_sel = req.now_ms;
            end
         end
         default: begin
            start_sel = cur.start;
         end
      endcase
   end

   assign diff    = req.now_ms - start_sel;
   assign reached = (diff >= req.preset_ms);

   always_comb begin
      nxt = cur;
      case (req.func)
         ltb_pkg::OP_ON_DELAY: begin
            if (req.rung) begin
               nxt.enabled = 1'b1;
               nxt.start   = start_sel;
               nxt.elapsed = diff;
               nxt.done    = reached;
               nxt.timing  = !reached;
            end else begin
               nxt.enabled = 1'b0;
               nxt.timing  = 1'b0;
               nxt.done    = 1'b0;
               nxt.elapsed = '0;
            end
         end
         ltb_pkg::OP_OFF_DELAY: begin
            if (req.rung) begin
               nxt.enabled = 1'b1;
               nxt.done    = 1'b1;
               nxt.timing  = 1'b0;
               nxt.elapsed = '0;
            end else if (cur.enabled) begin
               nxt.start   = start_sel;
               nxt.elapsed = diff;
               if (reached) begin
                  nxt.enabled = 1'b0;
                  nxt.timing  = 1'b0;
                  nxt.done    = 1'b0;
               end else begin
                  nxt.timing  = 1'b1;
               end
            end
         end
         ltb_pkg::OP_RESET: begin
            nxt = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign wr_en = in_range;

   always_comb begin
      if (in_range) begin
         rsp.enabled    = nxt.enabled;
         rsp.timing     = nxt.timing;
         rsp.done_res   = nxt.done;
         rsp.elapsed_ms = nxt.elapsed;
      end else begin
         rsp = '0;
      end
   end

endmodule

>>> hdl/ladder_on_off_delay_timer_bank.sv
// ---------------------------------------------------------------------------
// ladder_on_off_delay_timer_bank
// bank of on-delay / off-delay ladder timers kept in a state memory
// request transfer registers the request and reads the state memory; the run
// state registers the result and writes back; only then is a new request taken
// a new request is taken while an earlier result still waits
// reset: synchronous; per-entry valid bits clear so every timer reads as zero
// ---------------------------------------------------------------------------
module ladder_on_off_delay_timer_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ltb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ltb_pkg::rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic [ltb_pkg::NUM_TIMERS-1:0] valid_ff, valid_in;
   logic rd_valid_ff, rd_valid_in;
   ltb_pkg::req_type req_ff;
   ltb_pkg::rsp_type rsp_data_ff;
   logic rsp_valid_ff, rsp_valid_in;

   logic [ltb_pkg::ADDR_W-1:0] rd_addr;
   logic [ltb_pkg::ADDR_W-1:0] cur_addr;
   logic req_in_range;
   logic cur_in_range;
   logic req_xfer;
   logic finish;
   ltb_pkg::entry_type ram_rd;
   ltb_pkg::entry_type cur;
   ltb_pkg::entry_type nxt;
   logic step_wr_en;
   ltb_pkg::rsp_type step_rsp;
   ltb_pkg::ram_wr_type ram_wr;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_xfer     = req_valid && req_ready;
   assign rd_addr      = ltb_pkg::ADDR_W'(req_data.timer_index);
   assign cur_addr     = ltb_pkg::ADDR_W'(req_ff.timer_index);
   assign req_in_range = (32'(req_data.timer_index) < ltb_pkg::NUM_TIMERS);
   assign cur_in_range = (32'(req_ff.timer_index) < ltb_pkg::NUM_TIMERS);
   assign finish       = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign cur          = rd_valid_ff ? ram_rd : '0;

   ltb_state_ram u_ram (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (ram_rd),
      .wr      (ram_wr)
   );

   ltb_step_unit u_step (
      .req      (req_ff),
      .in_range (cur_in_range),
      .cur      (cur),
      .nxt      (nxt),
      .wr_en    (step_wr_en),
      .rsp      (step_rsp)
   );

   assign ram_wr.wr_en   = finish && step_wr_en;
   assign ram_wr.wr_addr = cur_addr;
   assign ram_wr.wr_data = nxt;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rd_valid_in = req_in_range && valid_ff[rd_addr];
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (step_wr_en) begin
                  valid_in[cur_addr] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
